[hw/rtl/clps_pkg.sv]
// shared types and constants for the clipped line pixel stepper
package clps_pkg;

    localparam int COORD_BITS = 12;
    localparam int WIN_BITS   = COORD_BITS - 1;
    localparam int COLOR_BITS = 32;

    // packed stream widths, rounded up to whole bytes
    localparam int S_TDATA_RAW = 4 * COORD_BITS + COLOR_BITS;
    localparam int M_TDATA_RAW = 2 * COORD_BITS + COLOR_BITS;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = CFG_IDX_W'(1);

    localparam logic [WIN_BITS-1:0] WINDOW_LOW_RESET  = WIN_BITS'(0);
    localparam logic [WIN_BITS-1:0] WINDOW_HIGH_RESET = WIN_BITS'(255);

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                           command;
        logic [COLOR_BITS-1:0]          line_color;
        logic signed [COORD_BITS-1:0]   end_y;
        logic signed [COORD_BITS-1:0]   end_x;
        logic signed [COORD_BITS-1:0]   start_y;
        logic signed [COORD_BITS-1:0]   start_x;
    } line_cmd_t;

    typedef struct packed {
        logic                           pixel_valid;
        logic [COLOR_BITS-1:0]          pixel_color;
        logic signed [COORD_BITS-1:0]   pixel_y;
        logic signed [COORD_BITS-1:0]   pixel_x;
        logic                           line_done;
    } pixel_rec_t;

endpackage

[hw/rtl/clps_core.sv]
// line state, loaded by a start word, and at most one bresenham step per fired step word
module clps_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            fire,
    input  clps_pkg::line_cmd_t             cmd,
    input  logic [clps_pkg::WIN_BITS-1:0]   window_low,
    input  logic [clps_pkg::WIN_BITS-1:0]   window_high,
    output clps_pkg::pixel_rec_t            result
);
    import clps_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int DX_W  = CW + 1;
    localparam int NDY_W = CW + 2;
    localparam int ERR_W = CW + 3;
    localparam int TW_W  = CW + 4;

    logic signed [CW-1:0]    cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [CW-1:0]    stop_x_reg, stop_x_next, stop_y_reg, stop_y_next;
    logic [DX_W-1:0]         delta_x_reg, delta_x_next;
    logic signed [NDY_W-1:0] neg_delta_y_reg, neg_delta_y_next;
    logic signed [ERR_W-1:0] error_reg, error_next;
    logic                    step_x_neg_reg, step_x_neg_next;
    logic                    step_y_neg_reg, step_y_neg_next;
    logic [COLOR_BITS-1:0]   color_reg, color_next;
    logic                    active_reg, active_next;

    // setup terms for a start word
    logic signed [DX_W-1:0]  diff_x;
    logic [DX_W-1:0]         abs_x;
    logic signed [NDY_W-1:0] diff_y;
    logic signed [NDY_W-1:0] ndy_init;
    logic signed [ERR_W-1:0] err_init;

    // step terms
    logic signed [CW:0]      lo_ext, hi_ext, cx_ext, cy_ext;
    logic                    x_in, y_in, at_end, emit;
    logic signed [TW_W-1:0]  twice;
    logic                    move_x, move_y;
    logic signed [ERR_W-1:0] err_stepped;

    always_comb begin
        diff_x   = DX_W'(cmd.end_x) - DX_W'(cmd.start_x);
        abs_x    = diff_x[DX_W-1] ? DX_W'(-diff_x) : DX_W'(diff_x);
        diff_y   = NDY_W'(cmd.end_y) - NDY_W'(cmd.start_y);
        ndy_init = diff_y[NDY_W-1] ? diff_y : -diff_y;
        err_init = ERR_W'(abs_x) + ERR_W'(ndy_init);
    end

    always_comb begin
        lo_ext = $signed({2'b00, window_low});
        hi_ext = $signed({2'b00, window_high});
        cx_ext = (CW+1)'(cur_x_reg);
        cy_ext = (CW+1)'(cur_y_reg);
        x_in   = (cx_ext > lo_ext) && (cx_ext <= hi_ext);
        y_in   = (cy_ext > lo_ext) && (cy_ext <= hi_ext);
        at_end = (cur_x_reg == stop_x_reg) && (cur_y_reg == stop_y_reg);
        emit   = active_reg && !at_end && x_in && y_in;

        twice  = $signed({error_reg, 1'b0});
        move_x = twice >= TW_W'(neg_delta_y_reg);
        move_y = twice <= $signed({3'b000, delta_x_reg});
        err_stepped = error_reg
                    + (move_x ? ERR_W'(neg_delta_y_reg) : ERR_W'(0))
                    + (move_y ? ERR_W'(delta_x_reg) : ERR_W'(0));
    end

    always_comb begin
        result.pixel_valid = emit;
        result.pixel_x     = emit ? cur_x_reg : '0;
        result.pixel_y     = emit ? cur_y_reg : '0;
        result.pixel_color = emit ? color_reg : '0;
        result.line_done   = !emit;
    end

    always_comb begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        stop_x_next      = stop_x_reg;
        stop_y_next      = stop_y_reg;
        delta_x_next     = delta_x_reg;
        neg_delta_y_next = neg_delta_y_reg;
        error_next       = error_reg;
        step_x_neg_next  = step_x_neg_reg;
        step_y_neg_next  = step_y_neg_reg;
        color_next       = color_reg;
        active_next      = active_reg;
        if (fire) begin
            if (cmd.command == CMD_START) begin
                cur_x_next       = cmd.start_x;
                cur_y_next       = cmd.start_y;
                stop_x_next      = cmd.end_x;
                stop_y_next      = cmd.end_y;
                delta_x_next     = abs_x;
                neg_delta_y_next = ndy_init;
                error_next       = err_init;
                step_x_neg_next  = !(cmd.start_x < cmd.end_x);
                step_y_neg_next  = !(cmd.start_y < cmd.end_y);
                color_next       = cmd.line_color;
                active_next      = 1'b1;
            end else if (emit) begin
                error_next = err_stepped;
                if (move_x) begin
                    cur_x_next = cur_x_reg + (step_x_neg_reg ? {CW{1'b1}} : CW'(1));
                end
                if (move_y) begin
                    cur_y_next = cur_y_reg + (step_y_neg_reg ? {CW{1'b1}} : CW'(1));
                end
            end else begin
                // endpoint reached, window left, or already idle
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        stop_x_reg      <= stop_x_next;
        stop_y_reg      <= stop_y_next;
        delta_x_reg     <= delta_x_next;
        neg_delta_y_reg <= neg_delta_y_next;
        error_reg       <= error_next;
        step_x_neg_reg  <= step_x_neg_next;
        step_y_neg_reg  <= step_y_neg_next;
        color_reg       <= color_next;
    end

`ifndef SYNTH
    // an emitted pixel always moves the line on at least one axis
    a_step_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && cmd.command == CMD_STEP && emit
        |=> (cur_x_reg != $past(cur_x_reg)) || (cur_y_reg != $past(cur_y_reg)))
        else $error("emitted pixel did not advance");

    a_emit_keeps_active: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && cmd.command == CMD_STEP && emit |=> active_reg)
        else $error("line went idle after emitting a pixel");

    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && cmd.command == CMD_START
        |=> active_reg && cur_x_reg == $past(cmd.start_x)
            && cur_y_reg == $past(cmd.start_y))
        else $error("start word did not load the line");

    a_idle_no_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> !result.pixel_valid && result.line_done)
        else $error("pixel produced while idle");
`endif

endmodule

[hw/rtl/clipped_line_pixel_stepper.sv]
// Clipped line pixel stepper: an all-octant Bresenham line generator clipped to a square
// window (low < x,y <= high). A start word (tuser 0) loads the endpoints and colour and
// gives no output word; each step word (tuser 1) gives one output word, either a pixel
// (m_tuser 1) or a done marker (m_tlast 1) once the endpoint is reached, the window is
// left, or no line is active. One word is accepted every clock unless the output stalls;
// a result passes the input and then the output register, with the step update itself a
// single compare-add between them. The user must write the window registers on the cfg
// channel (index 0 low, 1 high) only while the block is idle; nothing here enforces it.
module clipped_line_pixel_stepper (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_x, start_y, end_x, end_y, line_color
    input  logic [clps_pkg::S_TDATA_W-1:0]      s_tdata,
    // command
    input  logic                                s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [clps_pkg::M_TDATA_W-1:0]      m_tdata,
    // pixel_valid
    output logic                                m_tuser,
    // line_done
    output logic                                m_tlast,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [clps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clps_pkg::WIN_BITS-1:0]       cfg_data
);
    import clps_pkg::*;

    localparam int CW = COORD_BITS;

    logic                  in_valid_reg, in_valid_next;
    line_cmd_t             in_cmd_reg, in_cmd_next;
    logic                  out_valid_reg, out_valid_next;
    pixel_rec_t            out_reg, out_next;
    logic [WIN_BITS-1:0]   window_low_reg, window_low_next;
    logic [WIN_BITS-1:0]   window_high_reg, window_high_next;

    logic                  proc;
    logic                  out_load;
    line_cmd_t             s_cmd;
    pixel_rec_t            step_result;

    always_comb begin
        s_cmd.command    = cmd_t'(s_tuser);
        s_cmd.start_x    = s_tdata[CW-1:0];
        s_cmd.start_y    = s_tdata[2*CW-1:CW];
        s_cmd.end_x      = s_tdata[3*CW-1:2*CW];
        s_cmd.end_y      = s_tdata[4*CW-1:3*CW];
        s_cmd.line_color = s_tdata[4*CW+COLOR_BITS-1:4*CW];
    end

    // a start word needs no output slot
    assign proc = in_valid_reg
               && (in_cmd_reg.command == CMD_START || !out_valid_reg || m_tready);
    assign out_load = proc && in_cmd_reg.command == CMD_STEP;
    assign s_tready = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;

    clps_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (proc),
        .cmd         (in_cmd_reg),
        .window_low  (window_low_reg),
        .window_high (window_high_reg),
        .result      (step_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_cmd_next   = in_cmd_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_cmd_next   = s_cmd;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_next       = step_result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        window_low_next  = window_low_reg;
        window_high_next = window_high_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WINDOW_LOW:  window_low_next  = cfg_data;
                REG_WINDOW_HIGH: window_high_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            window_low_reg  <= WINDOW_LOW_RESET;
            window_high_reg <= WINDOW_HIGH_RESET;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            window_low_reg  <= window_low_next;
            window_high_reg <= window_high_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_cmd_reg <= in_cmd_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.pixel_color, out_reg.pixel_y, out_reg.pixel_x});
    assign m_tuser  = out_reg.pixel_valid;
    assign m_tlast  = out_reg.line_done;

`ifndef SYNTH
    a_step_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg && out_reg.line_done == !out_reg.pixel_valid)
        else $error("step word lost its result");

    a_start_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && in_cmd_reg.command == CMD_START && out_valid_reg && m_tready
        |=> !out_valid_reg)
        else $error("start word produced a result");

    a_held_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proc |-> !s_tready)
        else $error("input accepted over a held word");
`endif

endmodule
